FILE: design/byte_ring_fifo_unit_defines.svh
// ----------------------------------------------------------------------------
// Byte ring FIFO assertion macros
// Concurrent checks clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_FIFO_UNIT_DEFINES_SVH
`define BYTE_RING_FIFO_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define BRF_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define BRF_CHECK_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define BRF_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BRF_CHECK(lbl, cond, msg)
`define BRF_CHECK_IMP(lbl, ante, cons, msg)
`define BRF_CHECK_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: design/brf_pkg.sv
// ----------------------------------------------------------------------------
// Byte ring FIFO package
// Sizes, field widths, operation and status codes, controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package brf_pkg;

  localparam int DEPTH  = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PTR_W  = ADDR_W + 1;

  localparam int KIND_W = 3;
  localparam int BYTE_W = 8;
  localparam int AMT_W  = 11;
  localparam int STAT_W = 2;
  localparam int ES_W   = 7;

  localparam int IN_W    = ((BYTE_W + AMT_W + 7) / 8) * 8;
  localparam int OUT_RAW = STAT_W + BYTE_W + 3 * AMT_W;
  localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;
  localparam int OUT_PAD = OUT_W - OUT_RAW;

  localparam int DIV_CW = $clog2(PTR_W);

  typedef enum logic [KIND_W-1:0] {
    K_PUSH  = 3'd0,
    K_POP   = 3'd1,
    K_PEEK  = 3'd2,
    K_DROP  = 3'd3,
    K_FLUSH = 3'd4
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_SIZE  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DIV,
    S_HOLD
  } state_t;

endpackage

`default_nettype wire

FILE: design/brf_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data, no reset of contents.
// ----------------------------------------------------------------------------
`default_nettype none

module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: design/byte_ring_fifo_unit.sv
// ----------------------------------------------------------------------------
// Byte ring FIFO unit
// Push, flush, refused operations and drops with element size 0 or 1 finish
// at the accepting edge; the result is registered, via the hold register while
// the output stalls. Pop and peek pass through S_READ for the registered read
// of the ring RAM. A drop of a nonzero clamped length with element size above
// 1 runs the bit-serial remainder check in S_DIV. Reset clears the pointers
// and element size; the ring RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "byte_ring_fifo_unit_defines.svh"

module byte_ring_fifo_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [brf_pkg::IN_W-1:0]   s_tdata,    // data_in[7:0], amount[18:8]
  input  logic [brf_pkg::KIND_W-1:0] s_tuser,    // kind[2:0]
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [brf_pkg::OUT_W-1:0]  m_tdata,    // status[1:0], data_out[9:2],
                                                 // amount_done[20:10],
                                                 // fill_count[31:21],
                                                 // free_space[42:32]
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [brf_pkg::ES_W-1:0]   cfg_data    // elem_size
);

  import brf_pkg::*;

  state_t               state, state_next;
  logic [PTR_W-1:0]     wr_ptr, wr_next;
  logic [PTR_W-1:0]     rd_ptr, rd_next;
  logic [ES_W-1:0]      elem_size;
  logic [OUT_W-1:0]     hold;
  logic                 pend_pop;
  logic [PTR_W-1:0]     drop_len;
  logic [PTR_W-1:0]     div_q;
  logic [ES_W-1:0]      rem;
  logic [DIV_CW-1:0]    div_cnt;

  logic [BYTE_W-1:0]    in_data;
  logic [PTR_W-1:0]     in_amt;
  kind_t                in_kind;
  logic                 acc;
  logic                 out_free;
  logic                 es_big;
  logic [PTR_W-1:0]     cnt;
  logic [PTR_W-1:0]     clamp_len;
  logic [ES_W:0]        rem_sh;
  logic [ES_W-1:0]      rem_nx;

  logic                 fin;
  status_t              fin_status;
  logic [BYTE_W-1:0]    fin_data;
  logic [AMT_W-1:0]     fin_done;
  logic [PTR_W-1:0]     fin_cnt;
  logic [PTR_W-1:0]     fin_free;
  logic [OUT_W-1:0]     fin_res;
  logic                 out_load;
  logic                 pop_set, div_start, div_step;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [BYTE_W-1:0]    ram_rdata;

  brf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr[ADDR_W-1:0]),
    .wdata (in_data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_data   = s_tdata[BYTE_W-1:0];
  assign in_amt    = PTR_W'(s_tdata[BYTE_W +: AMT_W]);
  assign in_kind   = kind_t'(s_tuser);
  assign s_tready  = (state == S_IDLE) && !rst;
  assign cfg_ready = !rst;
  assign acc       = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign es_big    = elem_size > ES_W'(1);
  assign cnt       = wr_ptr - rd_ptr;
  assign clamp_len = (in_amt < cnt) ? in_amt : cnt;

  // one restoring remainder step per cycle, length bits from the top
  assign rem_sh = {rem, div_q[PTR_W-1]};
  assign rem_nx = (rem_sh >= {1'b0, elem_size}) ? ES_W'(rem_sh - {1'b0, elem_size})
                                                : ES_W'(rem_sh);

  always_comb begin
    state_next = state;
    wr_next    = wr_ptr;
    rd_next    = rd_ptr;
    fin        = 1'b0;
    fin_status = ST_OK;
    fin_data   = '0;
    fin_done   = '0;
    ram_we     = 1'b0;
    ram_raddr  = rd_ptr[ADDR_W-1:0];
    pop_set    = 1'b0;
    div_start  = 1'b0;
    div_step   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (acc) begin
          unique case (in_kind)
            K_PUSH: begin
              fin = 1'b1;
              if (es_big) begin
                fin_status = ST_SIZE;
              end else if (cnt >= PTR_W'(DEPTH)) begin
                fin_status = ST_FULL;
              end else begin
                ram_we   = 1'b1;
                wr_next  = wr_ptr + 1'b1;
                fin_done = AMT_W'(1);
              end
            end
            K_POP: begin
              if (es_big) begin
                fin        = 1'b1;
                fin_status = ST_SIZE;
              end else if (cnt == '0) begin
                fin        = 1'b1;
                fin_status = ST_EMPTY;
              end else begin
                rd_next    = rd_ptr + 1'b1;
                pop_set    = 1'b1;
                state_next = S_READ;
              end
            end
            K_PEEK: begin
              if (in_amt >= cnt) begin
                fin        = 1'b1;
                fin_status = ST_EMPTY;
              end else begin
                ram_raddr  = ADDR_W'(rd_ptr + in_amt);
                state_next = S_READ;
              end
            end
            K_DROP: begin
              if (es_big && clamp_len != '0) begin
                div_start  = 1'b1;
                state_next = S_DIV;
              end else begin
                fin      = 1'b1;
                rd_next  = rd_ptr + clamp_len;
                fin_done = AMT_W'(clamp_len);
              end
            end
            K_FLUSH: begin
              fin      = 1'b1;
              rd_next  = wr_ptr;
              fin_done = AMT_W'(cnt);
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        fin      = 1'b1;
        fin_data = ram_rdata;
        fin_done = pend_pop ? AMT_W'(1) : '0;
      end
      S_DIV: begin
        div_step = 1'b1;
        if (div_cnt == DIV_CW'(PTR_W - 1)) begin
          fin = 1'b1;
          if (rem_nx == '0) begin
            rd_next  = rd_ptr + drop_len;
            fin_done = AMT_W'(drop_len);
          end else begin
            fin_status = ST_SIZE;
          end
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (fin) begin
      state_next = out_free ? S_IDLE : S_HOLD;
    end
  end

  assign fin_cnt  = wr_next - rd_next;
  assign fin_free = PTR_W'(DEPTH) - fin_cnt;
  assign fin_res  = {{OUT_PAD{1'b0}}, AMT_W'(fin_free), AMT_W'(fin_cnt), fin_done,
                     fin_data, fin_status};
  assign out_load = out_free && (fin || state == S_HOLD);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      elem_size <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state  <= state_next;
      wr_ptr <= wr_next;
      rd_ptr <= rd_next;
      if (cfg_valid) begin
        elem_size <= cfg_data;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= (state == S_HOLD) ? hold : fin_res;
    end
    if (fin && !out_free) begin
      hold <= fin_res;
    end
    if (acc) begin
      pend_pop <= pop_set;
    end
    if (div_start) begin
      drop_len <= clamp_len;
      div_q    <= clamp_len;
      rem      <= '0;
      div_cnt  <= '0;
    end else if (div_step) begin
      div_q   <= {div_q[PTR_W-2:0], 1'b0};
      rem     <= rem_nx;
      div_cnt <= div_cnt + 1'b1;
    end
  end

  `BRF_CHECK(a_fill_range, cnt <= PTR_W'(DEPTH), "fill count above ring depth")
  `BRF_CHECK_IMP(a_hold_busy, state == S_HOLD, m_tvalid, "result held while output empty")
  `BRF_CHECK_IMP(a_rem_bound, state == S_DIV, rem < elem_size, "remainder not below elem_size")
  `BRF_CHECK_NEXT(a_push_adv, ram_we, wr_ptr == PTR_W'($past(wr_ptr) + 1'b1), "push stuck")

endmodule

`default_nettype wire
